// ===== design/pcode_pkg.sv =====
// Shared constants and types for the p-code stack machine execute block.
// No dependencies.
`default_nettype none

package pcode_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int MAX_LEVEL   = 15;
  localparam int WORD_WIDTH  = 32;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int LW  = 4;

  localparam logic [4:0] OP_LIT       = 5'd0;
  localparam logic [4:0] OP_OPR       = 5'd1;
  localparam logic [4:0] OP_LOD       = 5'd2;
  localparam logic [4:0] OP_STO       = 5'd3;
  localparam logic [4:0] OP_CAL       = 5'd4;
  localparam logic [4:0] OP_INT       = 5'd5;
  localparam logic [4:0] OP_JMP       = 5'd6;
  localparam logic [4:0] OP_JZ        = 5'd7;
  localparam logic [4:0] OP_HALT      = 5'd8;
  localparam logic [4:0] OP_NOP       = 5'd9;
  localparam logic [4:0] OP_PUSH      = 5'd10;
  localparam logic [4:0] OP_ADD       = 5'd11;
  localparam logic [4:0] OP_SUB       = 5'd12;
  localparam logic [4:0] OP_MUL       = 5'd13;
  localparam logic [4:0] OP_DIV       = 5'd14;
  localparam logic [4:0] OP_EMIT_INT  = 5'd15;
  localparam logic [4:0] OP_EMIT_ENUM = 5'd16;

  localparam logic [31:0] OPR_RET = 32'd0;
  localparam logic [31:0] OPR_NEG = 32'd1;
  localparam logic [31:0] OPR_ADD = 32'd2;
  localparam logic [31:0] OPR_DIV = 32'd5;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_OVF  = 2'd1,
    FLT_UNF  = 2'd2,
    FLT_ADR  = 2'd3
  } fault_e;

endpackage

`default_nettype wire

// ===== design/pcode_stack_machine_execute.sv =====
// PL/0-style p-code stack machine: executes one instruction per input beat.
// Stack words live in one synchronous RAM; depends on pcode_pkg.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one decoded
// instruction per beat; the output channel (out_valid_o / out_stall_i)
// returns one result beat per instruction with next pc, halt flag, printed
// value, top of stack, depth and fault code.
// One instruction is in flight at a time. LIT, PUSH, INT, JMP, HALT, NOP and
// steps that fault at decode go from decode straight to the top-of-stack
// read; the other steps first pass through their own RAM read and write
// states. Each static-link level walked adds one RAM read; a divide works
// one quotient bit per cycle plus the sign fix. The next beat is taken only
// after the result beat is accepted and the block is back in idle. The
// single-read-port stack RAM sets the pace of every step.
// At reset a clearing pass writes zero to all STACK_DEPTH words, one per
// cycle; in_stall_o stays high meanwhile.
// When the receiver stalls, the result holds on the output and no new
// instruction is taken until that beat is accepted.
`default_nettype none

module pcode_stack_machine_execute import pcode_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [4:0]                   req_type_i,
  input  wire logic [3:0]                   level_i,
  input  wire logic [15:0]                  address_i,
  input  wire logic signed [WORD_WIDTH-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [15:0]                       next_pc_o,
  output logic                              halted_o,
  output logic                              print_valid_o,
  output logic signed [WORD_WIDTH-1:0]      print_value_o,
  output logic signed [WORD_WIDTH-1:0]      top_value_o,
  output logic [SPW-1:0]                    stack_depth_o,
  output logic [1:0]                        fault_o
);

  localparam int WW  = WORD_WIDTH;
  localparam int NSW = WW + 2;
  localparam int DCW = $clog2(WW);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_WALK, S_WLD, S_LOD2, S_STO2, S_CAL1, S_CAL2,
    S_RET1, S_RET2, S_NEG, S_RDA, S_ALU, S_DIV, S_DIVW, S_ALUW, S_JZ, S_PRT,
    S_TOP, S_TOPC, S_OUT
  } state_e;

  logic [WW-1:0] mem [STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata_q;

  state_e         st_q, st_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [4:0]     op_q, op_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic [15:0]    adr_q, adr_d;
  logic [WW-1:0]  val_q, val_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [AW-1:0]  bp_q, bp_d;
  logic [15:0]    pc_q, pc_d, npc_q, npc_d;
  logic           halt_q, halt_d;
  fault_e         fault_q, fault_d;
  logic           pv_q, pv_d;
  logic [WW-1:0]  pval_q, pval_d;
  logic [WW-1:0]  b_q, b_d;
  logic [AW-1:0]  a_q, a_d;
  logic [1:0]     fn_q, fn_d;
  logic [WW-1:0]  opb_q, opb_d, res_q, res_d;
  logic [WW-1:0]  dq_q, dq_d, rem_q, rem_d, mb_q, mb_d;
  logic           neg_q, neg_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  logic           out_valid_q, out_valid_d;
  logic [15:0]    o_pc_q, o_pc_d;
  logic           o_halt_q, o_halt_d, o_pv_q, o_pv_d;
  logic [WW-1:0]  o_pval_q, o_pval_d, o_top_q, o_top_d;
  logic [SPW-1:0] o_sp_q, o_sp_d;
  logic [1:0]     o_flt_q, o_flt_d;

  logic [AW-1:0]  sp_m1, sp_m2, sp_lo;
  logic           sp_full;
  logic [NSW-1:0] ns;
  logic [WW:0]    fa, rsh, rsub;
  logic [WW-1:0]  ma, mb, qv;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    sp_lo   = sp_q[AW-1:0];
    sp_m1   = AW'(sp_q - SPW'(1));
    sp_m2   = AW'(sp_q - SPW'(2));
    sp_full = sp_q >= SPW'(STACK_DEPTH);
    ns      = NSW'(sp_q) + {{2{val_q[WW-1]}}, val_q};
    fa      = {1'b0, b_q} + (WW+1)'(adr_q);
    ma      = mem_rdata_q[WW-1] ? WW'(-mem_rdata_q) : mem_rdata_q;
    mb      = opb_q[WW-1] ? WW'(-opb_q) : opb_q;
    rsh     = {rem_q, dq_q[WW-1]};
    rsub    = rsh - {1'b0, mb_q};
    qv      = neg_q ? WW'(-dq_q) : dq_q;
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; op_d = op_q; lvl_d = lvl_q; adr_d = adr_q;
    val_d = val_q; sp_d = sp_q; bp_d = bp_q; pc_d = pc_q; npc_d = npc_q;
    halt_d = halt_q; fault_d = fault_q; pv_d = pv_q; pval_d = pval_q;
    b_d = b_q; a_d = a_q; fn_d = fn_q; opb_d = opb_q; res_d = res_q;
    dq_d = dq_q; rem_d = rem_q; mb_d = mb_q; neg_d = neg_q; dcnt_d = dcnt_q;
    out_valid_d = out_valid_q; o_pc_d = o_pc_q; o_halt_d = o_halt_q;
    o_pv_d = o_pv_q; o_pval_d = o_pval_q; o_top_d = o_top_q; o_sp_d = o_sp_q;
    o_flt_d = o_flt_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;

    case (st_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(STACK_DEPTH - 1)) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = req_type_i;
          lvl_d   = (int'(level_i) > MAX_LEVEL) ? LW'(MAX_LEVEL) : level_i;
          adr_d   = address_i;
          val_d   = value_i;
          npc_d   = pc_q + 16'd1;
          fault_d = FLT_NONE;
          pv_d    = 1'b0;
          pval_d  = '0;
          b_d     = WW'(bp_q);
          st_d    = S_DEC;
        end
      end
      S_DEC: begin
        st_d = S_TOP;
        if (halt_q) begin
          npc_d = pc_q;
        end else begin
          case (op_q)
            OP_LIT, OP_PUSH: begin
              if (sp_full) begin
                fault_d = FLT_OVF;
              end else begin
                mem_we = 1'b1; mem_waddr = sp_lo; mem_wdata = val_q;
                sp_d = sp_q + SPW'(1);
              end
            end
            OP_OPR: begin
              if (val_q == OPR_RET) begin
                if ((SPW'(bp_q) + SPW'(2)) >= SPW'(STACK_DEPTH)) begin
                  fault_d = FLT_ADR;
                end else begin
                  mem_raddr = bp_q + AW'(1);
                  st_d = S_RET1;
                end
              end else if (val_q == OPR_NEG) begin
                if (sp_q < SPW'(1)) begin
                  fault_d = FLT_UNF;
                end else begin
                  mem_raddr = sp_m1;
                  st_d = S_NEG;
                end
              end else if (val_q >= OPR_ADD && val_q <= OPR_DIV) begin
                fn_d = 2'(val_q - OPR_ADD);
                if (sp_q < SPW'(2)) begin
                  fault_d = FLT_UNF;
                end else begin
                  mem_raddr = sp_m1;
                  st_d = S_RDA;
                end
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              fn_d = 2'(op_q - OP_ADD);
              if (sp_q < SPW'(2)) begin
                fault_d = FLT_UNF;
              end else begin
                mem_raddr = sp_m1;
                st_d = S_RDA;
              end
            end
            OP_LOD: st_d = S_WALK;
            OP_STO: begin
              if (sp_q < SPW'(1)) begin
                fault_d = FLT_UNF;
              end else begin
                st_d = S_WALK;
              end
            end
            OP_CAL: begin
              if ((SPW+1)'(sp_q) + (SPW+1)'(3) > (SPW+1)'(STACK_DEPTH)) begin
                fault_d = FLT_OVF;
              end else begin
                st_d = S_WALK;
              end
            end
            OP_INT: begin
              if (ns[NSW-1]) begin
                fault_d = FLT_UNF;
              end else if (ns > NSW'(STACK_DEPTH)) begin
                fault_d = FLT_OVF;
              end else begin
                sp_d = SPW'(ns);
              end
            end
            OP_JMP: npc_d = adr_q;
            OP_JZ: begin
              if (sp_q < SPW'(1)) begin
                fault_d = FLT_UNF;
              end else begin
                mem_raddr = sp_m1;
                st_d = S_JZ;
              end
            end
            OP_HALT: begin
              halt_d = 1'b1;
              npc_d = pc_q;
            end
            OP_EMIT_INT, OP_EMIT_ENUM: begin
              if (sp_q < SPW'(1)) begin
                fault_d = FLT_UNF;
              end else begin
                mem_raddr = sp_m1;
                st_d = S_PRT;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (lvl_q != '0) begin
          if (b_q >= WW'(STACK_DEPTH)) begin
            fault_d = FLT_ADR;
            st_d = S_TOP;
          end else begin
            mem_raddr = b_q[AW-1:0];
            lvl_d = lvl_q - LW'(1);
            st_d = S_WLD;
          end
        end else if (op_q == OP_CAL) begin
          mem_we = 1'b1; mem_waddr = sp_lo; mem_wdata = b_q;
          st_d = S_CAL1;
        end else if (b_q >= WW'(STACK_DEPTH) || fa >= (WW+1)'(STACK_DEPTH)) begin
          fault_d = FLT_ADR;
          st_d = S_TOP;
        end else begin
          a_d = fa[AW-1:0];
          if (op_q == OP_LOD) begin
            if (sp_full) begin
              fault_d = FLT_OVF;
              st_d = S_TOP;
            end else begin
              mem_raddr = fa[AW-1:0];
              st_d = S_LOD2;
            end
          end else begin
            mem_raddr = sp_m1;
            st_d = S_STO2;
          end
        end
      end
      S_WLD: begin
        b_d = mem_rdata_q;
        st_d = S_WALK;
      end
      S_LOD2: begin
        mem_we = 1'b1; mem_waddr = sp_lo; mem_wdata = mem_rdata_q;
        sp_d = sp_q + SPW'(1);
        st_d = S_TOP;
      end
      S_STO2: begin
        mem_we = 1'b1; mem_waddr = a_q; mem_wdata = mem_rdata_q;
        sp_d = sp_q - SPW'(1);
        st_d = S_TOP;
      end
      S_CAL1: begin
        mem_we = 1'b1; mem_waddr = sp_lo + AW'(1); mem_wdata = WW'(bp_q);
        st_d = S_CAL2;
      end
      S_CAL2: begin
        mem_we = 1'b1; mem_waddr = sp_lo + AW'(2); mem_wdata = WW'(npc_q);
        bp_d = sp_lo;
        npc_d = adr_q;
        st_d = S_TOP;
      end
      S_RET1: begin
        b_d = mem_rdata_q;
        mem_raddr = bp_q + AW'(2);
        st_d = S_RET2;
      end
      S_RET2: begin
        if (b_q >= WW'(STACK_DEPTH)) begin
          fault_d = FLT_ADR;
        end else begin
          sp_d = SPW'(bp_q);
          npc_d = mem_rdata_q[15:0];
          bp_d = b_q[AW-1:0];
        end
        st_d = S_TOP;
      end
      S_NEG: begin
        mem_we = 1'b1; mem_waddr = sp_m1; mem_wdata = WW'(-mem_rdata_q);
        st_d = S_TOP;
      end
      S_RDA: begin
        opb_d = mem_rdata_q;
        mem_raddr = sp_m2;
        st_d = S_ALU;
      end
      S_ALU: begin
        st_d = S_ALUW;
        case (fn_q)
          ALU_ADD: res_d = mem_rdata_q + opb_q;
          ALU_SUB: res_d = mem_rdata_q - opb_q;
          ALU_MUL: res_d = WW'(mem_rdata_q * opb_q);
          default: begin
            dq_d = ma;
            mb_d = mb;
            rem_d = '0;
            neg_d = mem_rdata_q[WW-1] ^ opb_q[WW-1];
            dcnt_d = '0;
            st_d = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (!rsub[WW]) begin
          rem_d = rsub[WW-1:0];
          dq_d = {dq_q[WW-2:0], 1'b1};
        end else begin
          rem_d = rsh[WW-1:0];
          dq_d = {dq_q[WW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(WW - 1)) begin
          st_d = S_DIVW;
        end
      end
      S_DIVW: begin
        res_d = (mb_q == '0) ? '0 : qv;
        st_d = S_ALUW;
      end
      S_ALUW: begin
        mem_we = 1'b1; mem_waddr = sp_m2; mem_wdata = res_q;
        sp_d = sp_q - SPW'(1);
        st_d = S_TOP;
      end
      S_JZ: begin
        sp_d = sp_q - SPW'(1);
        if (mem_rdata_q == '0) begin
          npc_d = adr_q;
        end
        st_d = S_TOP;
      end
      S_PRT: begin
        sp_d = sp_q - SPW'(1);
        pv_d = 1'b1;
        pval_d = mem_rdata_q;
        st_d = S_TOP;
      end
      S_TOP: begin
        pc_d = npc_q;
        mem_raddr = sp_m1;
        st_d = S_TOPC;
      end
      S_TOPC: begin
        out_valid_d = 1'b1;
        o_pc_d = pc_q;
        o_halt_d = halt_q;
        o_pv_d = pv_q;
        o_pval_d = pval_q;
        o_top_d = (sp_q != '0) ? mem_rdata_q : '0;
        o_sp_d = sp_q;
        o_flt_d = fault_q;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; op_q <= '0; lvl_q <= '0; adr_q <= '0;
      val_q <= '0; sp_q <= '0; bp_q <= '0; pc_q <= '0; npc_q <= '0;
      halt_q <= 1'b0; fault_q <= FLT_NONE; pv_q <= 1'b0; pval_q <= '0;
      b_q <= '0; a_q <= '0; fn_q <= '0; opb_q <= '0; res_q <= '0;
      dq_q <= '0; rem_q <= '0; mb_q <= '0; neg_q <= 1'b0; dcnt_q <= '0;
      out_valid_q <= 1'b0; o_pc_q <= '0; o_halt_q <= 1'b0; o_pv_q <= 1'b0;
      o_pval_q <= '0; o_top_q <= '0; o_sp_q <= '0; o_flt_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; op_q <= op_d; lvl_q <= lvl_d; adr_q <= adr_d;
      val_q <= val_d; sp_q <= sp_d; bp_q <= bp_d; pc_q <= pc_d; npc_q <= npc_d;
      halt_q <= halt_d; fault_q <= fault_d; pv_q <= pv_d; pval_q <= pval_d;
      b_q <= b_d; a_q <= a_d; fn_q <= fn_d; opb_q <= opb_d; res_q <= res_d;
      dq_q <= dq_d; rem_q <= rem_d; mb_q <= mb_d; neg_q <= neg_d; dcnt_q <= dcnt_d;
      out_valid_q <= out_valid_d; o_pc_q <= o_pc_d; o_halt_q <= o_halt_d;
      o_pv_q <= o_pv_d; o_pval_q <= o_pval_d; o_top_q <= o_top_d;
      o_sp_q <= o_sp_d; o_flt_q <= o_flt_d;
    end
  end

  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = o_pc_q;
  assign halted_o      = o_halt_q;
  assign print_valid_o = o_pv_q;
  assign print_value_o = o_pval_q;
  assign top_value_o   = o_top_q;
  assign stack_depth_o = o_sp_q;
  assign fault_o       = o_flt_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE || st_q == S_OUT) |-> !mem_we) else $error("stray stack write");

endmodule

`default_nettype wire
